[rtl/core/cbd_pkg.sv]
// Shared constants and types for the clamp box downsampler.
`timescale 1ns / 1ps

package cbd_pkg;

  localparam int DEF_MAX_OUT_WIDTH = 256;
  localparam int DEF_BLOCK_SIDE    = 8;
  localparam int MAX_OUT_HEIGHT    = 256;
  localparam int SAMPLE_MAX        = 32767;
  localparam int QUEUE_DEPTH       = 4;

  localparam int SAMPLE_W  = 16;
  localparam int AVG_W     = 15;
  localparam int POS_W     = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(256);

  typedef struct packed {
    logic             first_sub_row;
    logic             last_sub_row;
    logic             frame_end;
    logic [POS_W-1:0] block_row;
  } cbd_ctl_t;

endpackage

[rtl/core/cbd_fifo.sv]
// Small register queue between the front and back parts.
`timescale 1ns / 1ps

module cbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cbd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  import cbd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[rtl/core/cbd_front.sv]
// Front part: sample clamp, position counters and horizontal block sums.
`timescale 1ns / 1ps

module cbd_front #(
  parameter int MAX_OUT_WIDTH = cbd_pkg::DEF_MAX_OUT_WIDTH,
  parameter int BLOCK_SIDE    = cbd_pkg::DEF_BLOCK_SIDE,
  localparam int PW  = $clog2(BLOCK_SIDE * cbd_pkg::SAMPLE_MAX + 1),
  localparam int CIW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [cbd_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                 in_frame_start,
  input  logic [cbd_pkg::CFG_W-1:0]            cfg_width,
  input  logic [cbd_pkg::CFG_W-1:0]            cfg_height,
  input  logic                                 q_full,
  output logic                                 q_push,
  output logic [PW-1:0]                        q_acc,
  output logic [CIW-1:0]                       q_ci,
  output cbd_pkg::cbd_ctl_t                    q_ctl
);
  import cbd_pkg::*;

  localparam int SW  = $clog2(BLOCK_SIDE);
  localparam int WBW = $clog2(MAX_OUT_WIDTH + 1);

  logic [SW-1:0]    sub_col_r, sub_col_nxt;
  logic [CIW-1:0]   col_r, col_nxt;
  logic [SW-1:0]    sub_row_r, sub_row_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [PW-1:0]    part_r, part_nxt;

  logic [WBW-1:0]   width_eff;
  logic [CFG_W-1:0] height_eff;
  logic [AVG_W-1:0] val;
  logic [SW-1:0]    sc, sr;
  logic [CIW-1:0]   col;
  logic [POS_W-1:0] row;
  logic [PW-1:0]    part, acc;
  logic [WBW:0]     col_inc;
  logic [CFG_W-1:0] row_inc;
  logic             last_sc, last_ci, last_sr, last_ri;
  logic             accept;

  always_comb begin
    if (cfg_width == '0) begin
      width_eff = WBW'(1);
    end else if (32'(cfg_width) > MAX_OUT_WIDTH) begin
      width_eff = WBW'(MAX_OUT_WIDTH);
    end else begin
      width_eff = WBW'(cfg_width);
    end
    if (cfg_height == '0) begin
      height_eff = CFG_W'(1);
    end else if (32'(cfg_height) > MAX_OUT_HEIGHT) begin
      height_eff = CFG_W'(MAX_OUT_HEIGHT);
    end else begin
      height_eff = cfg_height;
    end
  end

  assign val = in_sample[SAMPLE_W-1] ? '0 : in_sample[AVG_W-1:0];

  assign sc   = in_frame_start ? '0 : sub_col_r;
  assign col  = in_frame_start ? '0 : col_r;
  assign sr   = in_frame_start ? '0 : sub_row_r;
  assign row  = in_frame_start ? '0 : row_r;
  assign part = in_frame_start ? '0 : part_r;

  assign col_inc = {1'b0, WBW'(col)} + (WBW + 1)'(1);
  assign row_inc = {1'b0, row} + CFG_W'(1);

  assign last_sc = (sc == SW'(BLOCK_SIDE - 1));
  assign last_sr = (sr == SW'(BLOCK_SIDE - 1));
  assign last_ci = (col_inc >= {1'b0, width_eff});
  assign last_ri = (row_inc >= height_eff);

  assign acc = part + PW'(val);

  assign accept   = in_valid && in_ready;
  assign in_ready = !q_full;
  assign q_push   = accept && last_sc;
  assign q_acc    = acc;
  assign q_ci     = (WBW'(col) < width_eff) ? col : CIW'(width_eff - WBW'(1));

  always_comb begin
    q_ctl.first_sub_row = (sr == '0);
    q_ctl.last_sub_row  = last_sr;
    q_ctl.frame_end     = last_ci && last_ri;
    q_ctl.block_row     = ({1'b0, row} < height_eff) ? row
                                                     : POS_W'(height_eff - CFG_W'(1));
  end

  always_comb begin
    sub_col_nxt = last_sc ? '0 : sc + SW'(1);
    part_nxt    = last_sc ? '0 : acc;
    col_nxt     = col;
    sub_row_nxt = sr;
    row_nxt     = row;
    if (last_sc) begin
      if (!last_ci) begin
        col_nxt = col + CIW'(1);
      end else begin
        col_nxt = '0;
        if (!last_sr) begin
          sub_row_nxt = sr + SW'(1);
        end else begin
          sub_row_nxt = '0;
          row_nxt     = last_ri ? '0 : row + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_col_r <= '0;
      col_r     <= '0;
      sub_row_r <= '0;
      row_r     <= '0;
      part_r    <= '0;
    end else if (accept) begin
      sub_col_r <= sub_col_nxt;
      col_r     <= col_nxt;
      sub_row_r <= sub_row_nxt;
      row_r     <= row_nxt;
      part_r    <= part_nxt;
    end
  end

endmodule

[rtl/core/cbd_back.sv]
// Back part: column accumulator store, block mean and output register.
`timescale 1ns / 1ps

module cbd_back #(
  parameter int MAX_OUT_WIDTH = cbd_pkg::DEF_MAX_OUT_WIDTH,
  parameter int BLOCK_SIDE    = cbd_pkg::DEF_BLOCK_SIDE,
  localparam int PW  = $clog2(BLOCK_SIDE * cbd_pkg::SAMPLE_MAX + 1),
  localparam int CIW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  output logic                           q_pop,
  input  logic [PW-1:0]                  q_acc,
  input  logic [CIW-1:0]                 q_ci,
  input  cbd_pkg::cbd_ctl_t              q_ctl,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cbd_pkg::AVG_W-1:0]      out_average,
  output logic [cbd_pkg::POS_W-1:0]      out_block_column,
  output logic [cbd_pkg::POS_W-1:0]      out_block_row,
  output logic                           out_frame_end
);
  import cbd_pkg::*;

  localparam int  BLK_AREA  = BLOCK_SIDE * BLOCK_SIDE;
  localparam int  SUMW      = $clog2(BLK_AREA * SAMPLE_MAX + 1);
  localparam int  AREA_LOG  = $clog2(BLK_AREA);
  localparam bit  AREA_POW2 = ((BLK_AREA & (BLK_AREA - 1)) == 0);

  logic [SUMW-1:0]  col_sum_mem [MAX_OUT_WIDTH];

  logic             adv;
  logic             s1_vld_r;
  logic [PW-1:0]    s1_acc_r;
  logic [CIW-1:0]   s1_ci_r;
  cbd_ctl_t         s1_ctl_r;
  logic [SUMW-1:0]  rd_r;
  logic             byp_r, byp_nxt;
  logic [SUMW-1:0]  byp_val_r;
  logic [SUMW-1:0]  s1_base, sum_nxt;

  logic             s2_vld_r;
  logic [SUMW-1:0]  s2_sum_r;
  logic [CIW-1:0]   s2_ci_r;
  cbd_ctl_t         s2_ctl_r;
  logic [SUMW-1:0]  mean;

  logic             out_vld_r;
  logic [AVG_W-1:0] avg_r;
  logic [POS_W-1:0] bcol_r, brow_r;
  logic             fend_r;

  assign adv   = !out_vld_r || out_ready;
  assign q_pop = adv && !q_empty;

  assign s1_base = byp_r ? byp_val_r : rd_r;
  assign sum_nxt = s1_ctl_r.first_sub_row ? SUMW'(s1_acc_r) : s1_base + SUMW'(s1_acc_r);
  assign byp_nxt = s1_vld_r && (s1_ci_r == q_ci);

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r <= col_sum_mem[q_ci];
      if (s1_vld_r) begin
        col_sum_mem[s1_ci_r] <= sum_nxt;
      end
    end
  end

  generate
    if (AREA_POW2) begin : g_shift
      assign mean = s2_sum_r >> AREA_LOG;
    end else begin : g_recip
      localparam int SH = SUMW + AREA_LOG;
      localparam logic [SUMW:0] RECIP = (SUMW + 1)'(((64'd1 << SH) / BLK_AREA) + 64'd1);
      logic [2*SUMW:0] prod;
      assign prod = (2 * SUMW + 1)'(s2_sum_r) * (2 * SUMW + 1)'(RECIP);
      assign mean = SUMW'(prod >> SH);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= !q_empty;
      s2_vld_r  <= s1_vld_r && s1_ctl_r.last_sub_row;
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_acc_r  <= q_acc;
      s1_ci_r   <= q_ci;
      s1_ctl_r  <= q_ctl;
      byp_r     <= byp_nxt;
      byp_val_r <= sum_nxt;
      s2_sum_r  <= sum_nxt;
      s2_ci_r   <= s1_ci_r;
      s2_ctl_r  <= s1_ctl_r;
      avg_r     <= AVG_W'(mean);
      bcol_r    <= POS_W'(s2_ci_r);
      brow_r    <= s2_ctl_r.block_row;
      fend_r    <= s2_ctl_r.frame_end;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_average      = avg_r;
  assign out_block_column = bcol_r;
  assign out_block_row    = brow_r;
  assign out_frame_end    = fend_r;

endmodule

[rtl/core/clamp_box_downsample_8x8.sv]
// Top level of the clamp box downsampler.
//
// Input channel (in_*): one signed Q8.8 sample per beat in raster order;
// in_frame_start marks pixel (0,0) of a frame and realigns all counters.
// Negative samples count as zero. Every BLOCK_SIDE x BLOCK_SIDE block yields
// one beat on the output channel (out_*): its truncated mean, its block
// column and row, and out_frame_end on the last block of the frame.
// Config channel (cfg_*): index 0 sets the block columns per row, index 1
// the block rows per frame; both reset to 256 and are always ready.
// Throughput: one sample per cycle while the queue is not full. The front
// part counts positions and sums each block column of a sub-row; a
// four-entry queue feeds the back part, which does one read-modify-write
// of the column accumulator per beat. A block result passes through the
// queue, then the s1, s2 and output registers of the back part.
// Reset clears counters, queue and pipeline; the accumulator store is not
// cleared, since the first sub-row of each block overwrites it.
// When the receiver stalls, the output holds, the back part halts, and the
// input keeps taking beats until the queue fills.
`timescale 1ns / 1ps

module clamp_box_downsample_8x8 #(
  parameter int MAX_OUT_WIDTH = cbd_pkg::DEF_MAX_OUT_WIDTH,
  parameter int BLOCK_SIDE    = cbd_pkg::DEF_BLOCK_SIDE
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [cbd_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_frame_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cbd_pkg::AVG_W-1:0]           out_average,
  output logic [cbd_pkg::POS_W-1:0]           out_block_column,
  output logic [cbd_pkg::POS_W-1:0]           out_block_row,
  output logic                                out_frame_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cbd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cbd_pkg::CFG_W-1:0]           cfg_data
);
  import cbd_pkg::*;

  localparam int PW  = $clog2(BLOCK_SIDE * SAMPLE_MAX + 1);
  localparam int CIW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int QW  = $bits(cbd_ctl_t) + CIW + PW;

  logic [CFG_W-1:0] width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;

  logic             q_push, q_pop, q_full, q_empty;
  logic [PW-1:0]    f_acc, b_acc;
  logic [CIW-1:0]   f_ci, b_ci;
  cbd_ctl_t         f_ctl, b_ctl;
  logic [QW-1:0]    q_wr_data, q_rd_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OUT_WIDTH:  width_nxt  = cfg_data;
        REG_OUT_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  cbd_front #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .BLOCK_SIDE    (BLOCK_SIDE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_frame_start (in_frame_start),
    .cfg_width      (width_r),
    .cfg_height     (height_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_acc          (f_acc),
    .q_ci           (f_ci),
    .q_ctl          (f_ctl)
  );

  assign q_wr_data = {f_ctl, f_ci, f_acc};
  assign {b_ctl, b_ci, b_acc} = q_rd_data;

  cbd_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  cbd_back #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .BLOCK_SIDE    (BLOCK_SIDE)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .q_acc            (b_acc),
    .q_ci             (b_ci),
    .q_ctl            (b_ctl),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_average      (out_average),
    .out_block_column (out_block_column),
    .out_block_row    (out_block_row),
    .out_frame_end    (out_frame_end)
  );

endmodule

[rtl/core/cbd_checker.sv]
// Port-level assertions for the clamp box downsampler, bound to the top level.
`timescale 1ns / 1ps

module cbd_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic signed [cbd_pkg::SAMPLE_W-1:0] in_sample,
  input logic                                in_frame_start,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [cbd_pkg::AVG_W-1:0]           out_average,
  input logic [cbd_pkg::POS_W-1:0]           out_block_column,
  input logic [cbd_pkg::POS_W-1:0]           out_block_row,
  input logic                                out_frame_end,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [cbd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input logic [cbd_pkg::CFG_W-1:0]           cfg_data
);
  import cbd_pkg::*;

  logic fe_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_seen_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      fe_seen_r <= out_frame_end;
    end
  end

  a_reset_no_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output beat right after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average)
      && $stable(out_block_column) && $stable(out_block_row) && $stable(out_frame_end))
    else $error("stalled output beat changed");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fe_seen_r |-> out_block_column == '0 && out_block_row == '0)
    else $error("block after frame end is not at the origin");

endmodule

bind clamp_box_downsample_8x8 cbd_checker u_cbd_checker (.*);

[test/clamp_box_downsample_8x8_test.sv]
// Self-checking testbench for the clamp box downsampler: predicts every block mean and compares.
`timescale 1ns / 1ps

module clamp_box_downsample_8x8_test;

  import cbd_pkg::*;

  localparam int unsigned MAX_COLS       = DEF_MAX_OUT_WIDTH;
  localparam int unsigned BLOCK          = DEF_BLOCK_SIDE;
  localparam int unsigned MEAN_SHIFT     = $clog2(BLOCK * BLOCK);
  localparam int unsigned ACC_W          = 22;
  localparam int unsigned STRIP_W        = 18;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned RANDOM_ITEMS   = 64;
  localparam int unsigned RANDOM_MEANS   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(15);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP     = SAMPLE_W'(SAMPLE_MAX);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOTTOM  = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_NEG_ONE = '1;

  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic             frame_end;
  } block_mean_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_frame_start;
  logic                       out_valid;
  logic                       out_ready;
  logic [AVG_W-1:0]           out_average;
  logic [POS_W-1:0]           out_block_column;
  logic [POS_W-1:0]           out_block_row;
  logic                       out_frame_end;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_data;

  // Predictor state
  logic [CFG_W-1:0]   width_setting  = DIM_RESET;
  logic [CFG_W-1:0]   height_setting = DIM_RESET;
  logic [ACC_W-1:0]   col_acc [MAX_COLS];
  logic [STRIP_W-1:0] strip_sum     = '0;
  int unsigned        px_in_block   = 0;
  int unsigned        blk_col       = 0;
  int unsigned        line_in_block = 0;
  int unsigned        blk_row       = 0;

  block_mean_t pending_means[$];
  int unsigned means_predicted = 0;
  int unsigned mismatches      = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned hold_request    = 0;
  bit          sender_idles    = 1'b1;
  bit          receiver_idles  = 1'b1;

  clamp_box_downsample_8x8 u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_average      (out_average),
    .out_block_column (out_block_column),
    .out_block_row    (out_block_row),
    .out_frame_end    (out_frame_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned dim_in_use(input logic [CFG_W-1:0] v, input int unsigned limit);
    if (v == '0) return 1;
    return (32'(v) > limit) ? limit : 32'(v);
  endfunction

  function automatic void accumulate_sample(input logic signed [SAMPLE_W-1:0] smp, input logic fs);
    int unsigned        cols;
    int unsigned        rows;
    int unsigned        ci;
    logic [SAMPLE_W-1:0] level;
    logic [STRIP_W-1:0] strip;
    logic               last_px;
    logic               last_col;
    logic               last_line;
    logic               last_row;
    block_mean_t        mean;
    cols = dim_in_use(width_setting, MAX_COLS);
    rows = dim_in_use(height_setting, MAX_OUT_HEIGHT);
    if (fs) begin
      px_in_block   = 0;
      blk_col       = 0;
      line_in_block = 0;
      blk_row       = 0;
      strip_sum     = '0;
    end
    last_px   = px_in_block + 1 >= BLOCK;
    last_col  = blk_col + 1 >= cols;
    last_line = line_in_block + 1 >= BLOCK;
    last_row  = blk_row + 1 >= rows;
    level = smp[SAMPLE_W-1] ? '0 : smp;
    strip = strip_sum + STRIP_W'(level);
    if (!last_px) begin
      strip_sum = strip;
      px_in_block++;
      return;
    end
    ci = (blk_col < cols) ? blk_col : cols - 1;
    if (line_in_block == 0) col_acc[ci] = ACC_W'(strip);
    else col_acc[ci] = col_acc[ci] + ACC_W'(strip);
    strip_sum   = '0;
    px_in_block = 0;
    if (last_line) begin
      mean.average   = AVG_W'(col_acc[ci] >> MEAN_SHIFT);
      mean.column    = POS_W'(ci);
      mean.row       = POS_W'((blk_row < rows) ? blk_row : rows - 1);
      mean.frame_end = last_col && last_row;
      pending_means.push_back(mean);
      means_predicted++;
    end
    if (!last_col) begin
      blk_col++;
    end else begin
      blk_col = 0;
      if (!last_line) begin
        line_in_block++;
      end else begin
        line_in_block = 0;
        blk_row = last_row ? 0 : blk_row + 1;
      end
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_TOP;
      1: return SAMPLE_BOTTOM;
      2: return '0;
      3: return SAMPLE_NEG_ONE;
      4: return SAMPLE_W'($urandom_range(0, 255));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp, input logic fs);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= smp;
    in_frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accumulate_sample(smp, fs);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val,
                          input bit close_burst);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_OUT_WIDTH) width_setting = val;
    else if (idx == REG_OUT_HEIGHT) height_setting = val;
    if (close_burst) cfg_valid <= 1'b0;
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
    wait_results();
    send_reg(REG_OUT_WIDTH, cols, 1'b0);
    send_reg(REG_OUT_HEIGHT, rows, 1'b1);
  endtask

  task automatic test_clamp_extremes();
    int i;
    set_dims(CFG_W'(1), CFG_W'(1));
    for (i = 0; i < 64; i++) push_sample(SAMPLE_TOP, i == 0);
    for (i = 0; i < 64; i++)
      push_sample(i[0] ? SAMPLE_TOP : (i[1] ? SAMPLE_BOTTOM : SAMPLE_NEG_ONE), i == 0);
  endtask

  task automatic test_register_limits();
    int i;
    wait_results();
    send_reg(REG_OUT_WIDTH, '0, 1'b0);
    send_reg(REG_OUT_HEIGHT, '1, 1'b0);
    send_reg(REG_UNUSED, '1, 1'b1);
    for (i = 0; i < 64; i++) push_sample(pick_sample(), i == 0);
    set_dims(CFG_W'(1), '0);
    for (i = 0; i < 64; i++) push_sample(pick_sample(), i == 0);
  endtask

  task automatic test_frame_resync();
    int i;
    set_dims(CFG_W'(1), CFG_W'(1));
    for (i = 0; i < 24; i++) push_sample(pick_sample(), i == 0);
    for (i = 0; i < 64; i++) push_sample(pick_sample(), i == 0);
  endtask

  task automatic test_mid_frame_resize();
    int i;
    set_dims(CFG_W'(1), CFG_W'(3));
    for (i = 0; i < 64; i++) push_sample(pick_sample(), i == 0);
    set_dims(CFG_W'(1), CFG_W'(1));
    for (i = 0; i < 64; i++) push_sample(pick_sample(), 1'b0);
    set_dims(CFG_W'(4), CFG_W'(1));
    for (i = 0; i < 24; i++) push_sample(pick_sample(), i == 0);
    set_dims(CFG_W'(2), CFG_W'(1));
    for (i = 0; i < 120; i++) push_sample(pick_sample(), 1'b0);
  endtask

  task automatic test_widest_row();
    int i;
    set_dims(CFG_W'(300), CFG_W'(1));
    for (i = 0; i < 8 * BLOCK; i++) push_sample(pick_sample(), i == 0);
    set_dims(CFG_W'(1), CFG_W'(1));
    for (i = 0; i < 7 * BLOCK; i++) push_sample(pick_sample(), 1'b0);
    set_dims('1, CFG_W'(1));
    for (i = 0; i < 8 * BLOCK; i++) push_sample(pick_sample(), 1'b0);
  endtask

  task automatic test_receiver_hold();
    int i;
    set_dims(CFG_W'(1), CFG_W'(1));
    hold_request = HOLD_CYCLES;
    for (i = 0; i < 128; i++) push_sample(pick_sample(), i == 0);
    wait_results();
  endtask

  task automatic test_random_frames();
    logic [CFG_W-1:0] cols;
    logic [CFG_W-1:0] rows;
    int unsigned      frame_len;
    int unsigned      n;
    int unsigned      i;
    int unsigned      items_sent;
    int unsigned      means_at_start;
    items_sent     = 0;
    means_at_start = means_predicted;
    while (items_sent < RANDOM_ITEMS || means_predicted - means_at_start < RANDOM_MEANS) begin
      case ($urandom_range(0, 9))
        0: cols = '0;
        1: cols = CFG_W'($urandom_range(5, 511));
        default: cols = CFG_W'($urandom_range(1, 2));
      endcase
      case ($urandom_range(0, 9))
        0: rows = '0;
        1: rows = CFG_W'($urandom_range(3, 511));
        default: rows = CFG_W'($urandom_range(1, 2));
      endcase
      frame_len = dim_in_use(cols, MAX_COLS) * dim_in_use(rows, MAX_OUT_HEIGHT) * BLOCK * BLOCK;
      if (frame_len > 256) begin
        n = $urandom_range(64, 192);
      end else begin
        case ($urandom_range(0, 5))
          0: n = $urandom_range(1, frame_len);
          1: n = frame_len + $urandom_range(1, 128);
          default: n = frame_len;
        endcase
      end
      set_dims(cols, rows);
      for (i = 0; i < n; i++)
        push_sample(pick_sample(), i == 0 || $urandom_range(0, 299) == 0);
      items_sent += n;
    end
  endtask

  task automatic test_steady_stream();
    int i;
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    set_dims(CFG_W'(2), CFG_W'(1));
    for (i = 0; i < 2 * 64; i++) push_sample(pick_sample(), i == 0);
  endtask

  initial begin : receiver
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        out_ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    block_mean_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_means.size() == 0) begin
        $display("%0t: block mean expected none, actual average %0d column %0d row %0d",
                 $time, out_average, out_block_column, out_block_row);
        mismatches++;
      end else begin
        want = pending_means.pop_front();
        if (out_average !== want.average) begin
          $display("%0t: average expected %0d actual %0d", $time, want.average, out_average);
          mismatches++;
        end
        if (out_block_column !== want.column) begin
          $display("%0t: block_column expected %0d actual %0d",
                   $time, want.column, out_block_column);
          mismatches++;
        end
        if (out_block_row !== want.row) begin
          $display("%0t: block_row expected %0d actual %0d", $time, want.row, out_block_row);
          mismatches++;
        end
        if (out_frame_end !== want.frame_end) begin
          $display("%0t: frame_end expected %0b actual %0b",
                   $time, want.frame_end, out_frame_end);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_valid       <= 1'b0;
    in_sample      <= '0;
    in_frame_start <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    rst_n          <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_clamp_extremes();
    test_register_limits();
    test_frame_resync();
    test_mid_frame_resize();
    test_widest_row();
    test_receiver_hold();
    test_random_frames();
    test_steady_stream();
    wait_results();
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
